>>> hdl/efc_pkg.sv
// ----------------------------------------------------------------------------
// efc_pkg
// Shared types, constants and helpers for the Euler flux pipeline.
// ----------------------------------------------------------------------------
package efc_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned GM1_W    = 18;
  localparam int unsigned KIN_QW   = 49;
  localparam int unsigned FLX_QW   = 34;
  localparam logic [GM1_W-1:0] GM1_RESET = 18'd26214;

  typedef struct packed {
    logic [31:0]      rho;
    logic [31:0]      e;
    logic [2:0][31:0] m;
    logic             bad;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [31:0] p;
    logic        epneg;
  } tail_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? 32'(-v) : v;
  endfunction

  function automatic logic [31:0] sat36(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'h7FFF_FFFF;
    else if (v < -36'sd2147483648) return 32'h8000_0000;
    else return v[31:0];
  endfunction

  function automatic logic [31:0] signed_q(input logic [FLX_QW-1:0] q, input logic neg,
                                           input logic [31:0] p, input logic add_p);
    logic signed [35:0] s;
    s = $signed({2'b00, q});
    if (neg) s = -s;
    if (add_p) s = s + 36'($signed(p));
    return sat36(s);
  endfunction

endpackage

>>> hdl/euler_flux_from_conserved.sv
// ----------------------------------------------------------------------------
// euler_flux_from_conserved
// Inviscid ideal-gas Euler flux of one cell, emitted one flux row per word.
// ----------------------------------------------------------------------------
//  channel  | handshake         | payload
//  input    | start / busy      | in_density, in_energy, in_momentum_x/y/z
//  result   | out_strobe        | out_row_index, out_flux_x/y/z, out_cell_pressure,
//           |                   | out_last_row, out_bad_density
//  config   | cfg_we            | cfg_wdata (gamma minus one)
//
//  The result port emits one row per cycle; busy stays high after each accepted
//  cell, so a new cell is accepted only once busy has fallen. The path to the
//  first row runs through the 50-stage kinetic divider and the 35-stage flux
//  dividers. Reset is synchronous, active low; it clears valid bits and
//  counters and restores config to its reset value. The receiver cannot stall;
//  every word leaves on its strobe cycle.
// ----------------------------------------------------------------------------
module euler_flux_from_conserved #(
  parameter int unsigned DIMENSIONS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_density,
  input  logic [31:0] in_energy,
  input  logic [31:0] in_momentum_x,
  input  logic [31:0] in_momentum_y,
  input  logic [31:0] in_momentum_z,
  input  logic        cfg_we,
  input  logic [17:0] cfg_wdata,
  output logic        out_strobe,
  output logic [2:0]  out_row_index,
  output logic [31:0] out_flux_x,
  output logic [31:0] out_flux_y,
  output logic [31:0] out_flux_z,
  output logic [31:0] out_cell_pressure,
  output logic        out_last_row,
  output logic        out_bad_density
);

  localparam int unsigned ROWS  = DIMENSIONS + 2;
  localparam int unsigned ROW_W = $clog2(ROWS);
  localparam int unsigned LOAD  = 2 + (efc_pkg::KIN_QW + 1) + 5 + (efc_pkg::FLX_QW + 1);

  logic                      accept;
  logic [efc_pkg::GM1_W-1:0] gm1_r;
  logic [ROW_W-1:0]          gap_r;
  logic                      vld_r [0:LOAD];

  efc_pkg::side_t side_in, side0_r, side1_r, side2_r, side52;
  efc_pkg::side_t side53_r, side54_r, side55_r, side56_r, side57_r;
  efc_pkg::tail_t tail57, tail92;

  logic [63:0]              sq_r [0:2];
  logic [32:0]              den1_r, den2_r;
  logic [63:0]              msq_r;
  logic [efc_pkg::KIN_QW-1:0] kin;
  logic signed [50:0]       diff_r;
  logic [50:0]              dmag;
  logic [64:0]              prod_r;
  logic                     big_r, neg54_r;
  logic [48:0]              rsh;
  logic                     psat;
  logic [31:0]              p_nxt, p55_r, p56_r, p57_r;
  logic signed [32:0]       ep_r;
  logic [32:0]              epmag;
  logic                     epneg57_r;
  logic [63:0]              pe_r [0:2];
  logic [63:0]              pmm_r [0:2][0:2];
  logic [efc_pkg::FLX_QW-1:0] qe [0:2];
  logic [efc_pkg::FLX_QW-1:0] qm [0:2][0:2];

  logic [2:0][31:0]         rows_nxt [0:ROWS-1];
  logic [2:0][31:0]         rowbuf_r [0:ROWS-1];
  logic [31:0]              hold_p_r;
  logic                     hold_bad_r;
  logic                     act_r;
  logic [ROW_W-1:0]         row_r;

  logic                     out_strobe_r, out_last_r, out_bad_r;
  logic [2:0]               out_row_r;
  logic [2:0][31:0]         out_flux_r;
  logic [31:0]              out_p_r;

  assign busy   = gap_r != '0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gm1_r <= efc_pkg::GM1_RESET;
    end else if (cfg_we) begin
      gm1_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= '0;
    end else if (accept) begin
      gap_r <= ROW_W'(ROWS - 1);
    end else if (gap_r != '0) begin
      gap_r <= gap_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= LOAD; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[0] <= accept;
      for (int k = 1; k <= LOAD; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_comb begin
    side_in.bad  = in_density[31] || (in_density == '0);
    side_in.rho  = side_in.bad ? 32'd1 : in_density;
    side_in.e    = in_energy;
    side_in.m[0] = in_momentum_x;
    side_in.m[1] = (DIMENSIONS > 1) ? in_momentum_y : '0;
    side_in.m[2] = (DIMENSIONS > 2) ? in_momentum_z : '0;
  end

  // front: squares, |m|^2, kinetic divide
  always_ff @(posedge clk) begin
    if (accept) side0_r <= side_in;
    side1_r <= side0_r;
    den1_r  <= {side0_r.rho, 1'b0};
    for (int j = 0; j < 3; j++) begin
      sq_r[j] <= 64'(efc_pkg::mag32(side0_r.m[j])) * 64'(efc_pkg::mag32(side0_r.m[j]));
    end
    side2_r <= side1_r;
    den2_r  <= den1_r;
    msq_r   <= sq_r[0] + sq_r[1] + sq_r[2];
  end

  efc_div #(.NW(64), .DW(33), .QW(efc_pkg::KIN_QW)) u_kin_div (
    .clk(clk), .num(msq_r), .den(den2_r), .quo(kin)
  );

  efc_delay #(.W($bits(efc_pkg::side_t)), .DEPTH(efc_pkg::KIN_QW + 1)) u_side_dly (
    .clk(clk), .din(side2_r), .dout(side52)
  );

  // pressure
  assign dmag  = diff_r[50] ? 51'(-diff_r) : diff_r;
  assign rsh   = prod_r[64:16];
  assign psat  = big_r || (|rsh[48:31]);
  assign p_nxt = neg54_r ? (psat ? 32'h8000_0000 : 32'(-$signed({1'b0, rsh[30:0]})))
                         : (psat ? 32'h7FFF_FFFF : {1'b0, rsh[30:0]});
  assign epmag = ep_r[32] ? 33'(-ep_r) : ep_r;

  always_ff @(posedge clk) begin
    side53_r <= side52;
    diff_r   <= 51'($signed(side52.e)) - $signed({2'b00, kin});
    side54_r <= side53_r;
    prod_r   <= 65'(dmag[46:0]) * 65'(gm1_r);
    big_r    <= (|dmag[50:47]) && (gm1_r != '0);
    neg54_r  <= diff_r[50];
    side55_r <= side54_r;
    p55_r    <= p_nxt;
    side56_r <= side55_r;
    p56_r    <= p55_r;
    ep_r     <= 33'($signed(side55_r.e)) + 33'($signed(p55_r));
    side57_r <= side56_r;
    p57_r    <= p56_r;
    epneg57_r <= ep_r[32];
    for (int j = 0; j < 3; j++) begin
      pe_r[j] <= 64'(65'(efc_pkg::mag32(side56_r.m[j])) * 65'(epmag));
      for (int i = 0; i < 3; i++) begin
        pmm_r[i][j] <= 64'(efc_pkg::mag32(side56_r.m[i])) *
                       64'(efc_pkg::mag32(side56_r.m[j]));
      end
    end
  end

  // flux dividers
  for (genvar j = 0; j < 3; j++) begin : g_col
    efc_div #(.NW(64), .DW(32), .QW(efc_pkg::FLX_QW)) u_e_div (
      .clk(clk), .num(pe_r[j]), .den(side57_r.rho), .quo(qe[j])
    );
    for (genvar i = 0; i < 3; i++) begin : g_row
      efc_div #(.NW(64), .DW(32), .QW(efc_pkg::FLX_QW)) u_m_div (
        .clk(clk), .num(pmm_r[i][j]), .den(side57_r.rho), .quo(qm[i][j])
      );
    end
  end

  assign tail57.side  = side57_r;
  assign tail57.p     = p57_r;
  assign tail57.epneg = epneg57_r;

  efc_delay #(.W($bits(efc_pkg::tail_t)), .DEPTH(efc_pkg::FLX_QW + 1)) u_tail_dly (
    .clk(clk), .din(tail57), .dout(tail92)
  );

  always_comb begin
    for (int r = 0; r < ROWS; r++) rows_nxt[r] = '0;
    for (int j = 0; j < 3; j++) begin
      rows_nxt[0][j] = tail92.side.m[j];
      rows_nxt[1][j] = efc_pkg::signed_q(qe[j], tail92.side.m[j][31] ^ tail92.epneg,
                                         tail92.p, 1'b0);
      for (int i = 0; i < DIMENSIONS; i++) begin
        rows_nxt[2+i][j] = efc_pkg::signed_q(qm[i][j],
                                             tail92.side.m[i][31] ^ tail92.side.m[j][31],
                                             tail92.p, i == j);
      end
    end
    if (tail92.side.bad) begin
      for (int r = 0; r < ROWS; r++) rows_nxt[r] = '0;
    end
  end

  // row buffer and output sequencer
  always_ff @(posedge clk) begin
    if (vld_r[LOAD]) begin
      for (int r = 0; r < ROWS; r++) rowbuf_r[r] <= rows_nxt[r];
      hold_p_r   <= tail92.side.bad ? '0 : tail92.p;
      hold_bad_r <= tail92.side.bad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      row_r <= '0;
    end else if (vld_r[LOAD]) begin
      act_r <= 1'b1;
      row_r <= '0;
    end else if (act_r) begin
      if (row_r == ROW_W'(ROWS - 1)) act_r <= 1'b0;
      row_r <= row_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= act_r;
    end
  end

  always_ff @(posedge clk) begin
    out_row_r  <= 3'(row_r);
    out_flux_r <= rowbuf_r[row_r];
    out_p_r    <= hold_p_r;
    out_last_r <= row_r == ROW_W'(ROWS - 1);
    out_bad_r  <= hold_bad_r;
  end

  assign out_strobe        = out_strobe_r;
  assign out_row_index     = out_row_r;
  assign out_flux_x        = out_flux_r[0];
  assign out_flux_y        = out_flux_r[1];
  assign out_flux_z        = out_flux_r[2];
  assign out_cell_pressure = out_p_r;
  assign out_last_row      = out_last_r;
  assign out_bad_density   = out_bad_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("busy not raised after accept");

  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_last_row == (out_row_index == 3'(ROWS - 1))))
    else $error("last_row mismatch");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_bad_density) |-> (out_flux_x == '0 && out_flux_y == '0 &&
                                         out_flux_z == '0 && out_cell_pressure == '0))
    else $error("bad density word carries nonzero flux");

  a_rows_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_row_index != '0) |-> $past(out_strobe))
    else $error("row gap inside a cell");

endmodule

>>> hdl/efc_delay.sv
// ----------------------------------------------------------------------------
// efc_delay
// Fixed-depth shift line that carries side data next to a long datapath.
// ----------------------------------------------------------------------------
module efc_delay #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] tap_r [0:DEPTH-1];

  always_ff @(posedge clk) begin
    tap_r[0] <= din;
    for (int k = 1; k < DEPTH; k++) begin
      tap_r[k] <= tap_r[k-1];
    end
  end

  assign dout = tap_r[DEPTH-1];

endmodule

>>> hdl/efc_div.sv
// ----------------------------------------------------------------------------
// efc_div
// Pipelined restoring divider, one quotient bit per stage, saturating.
// ----------------------------------------------------------------------------
module efc_div #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 32,
  parameter int unsigned QW = 34
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [NW-1:0] hi;
  logic [DW-1:0] rem_r [0:QW];
  logic [DW-1:0] den_r [0:QW];
  logic [QW-1:0] lo_r  [0:QW];
  logic [QW-1:0] q_r   [0:QW];
  logic          ovf_r [0:QW];

  assign hi = num >> QW;

  always_ff @(posedge clk) begin
    ovf_r[0] <= hi >= NW'(den);
    rem_r[0] <= hi[DW-1:0];
    den_r[0] <= den;
    lo_r[0]  <= num[QW-1:0];
    q_r[0]   <= '0;
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [DW:0] t;
    logic        ge;
    assign t  = {rem_r[k-1], lo_r[k-1][QW-k]};
    assign ge = t >= {1'b0, den_r[k-1]};
    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? DW'(t - {1'b0, den_r[k-1]}) : t[DW-1:0];
      q_r[k]   <= {q_r[k-1][QW-2:0], ge};
      den_r[k] <= den_r[k-1];
      lo_r[k]  <= lo_r[k-1];
      ovf_r[k] <= ovf_r[k-1];
    end
  end

  assign quo = ovf_r[QW] ? '1 : q_r[QW];

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler flux block testbench
// Drives cells of conserved variables through the start/busy port, predicts
// every flux row (mass, energy and momentum rows) and the cell pressure in
// fixed point and checks each strobed result word against the oldest
// prediction. Gamma minus one is swept through its extremes between phases.
// ----------------------------------------------------------------------------
module tb;

  localparam int DIMS     = 3;
  localparam int LATENCY  = 110;
  localparam int MAX_GAP  = 13;

  typedef struct {
    logic [2:0]  row;
    logic [31:0] fx, fy, fz, p;
    logic        last, bad;
  } flux_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_density = '0, in_energy = '0;
  logic [31:0] in_momentum_x = '0, in_momentum_y = '0, in_momentum_z = '0;
  logic        cfg_we = 1'b0;
  logic [17:0] cfg_wdata = '0;
  logic        out_strobe;
  logic [2:0]  out_row_index;
  logic [31:0] out_flux_x, out_flux_y, out_flux_z, out_cell_pressure;
  logic        out_last_row, out_bad_density;

  flux_row_t   flux_rows_due[$];
  logic [17:0] gm1 = efc_pkg::GM1_RESET;
  int          n_errors = 0;
  int          n_cells = 0;
  int          n_rows = 0;
  int          n_bad_cells = 0;

  always #2 clk = ~clk;

  euler_flux_from_conserved #(.DIMENSIONS(DIMS)) u_dut (
    .clk, .rst_n, .start, .busy,
    .in_density, .in_energy, .in_momentum_x, .in_momentum_y, .in_momentum_z,
    .cfg_we, .cfg_wdata,
    .out_strobe, .out_row_index, .out_flux_x, .out_flux_y, .out_flux_z,
    .out_cell_pressure, .out_last_row, .out_bad_density
  );

  function automatic logic [63:0] absu(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic longint scaled_quot(input longint a, input longint b,
                                         input logic [63:0] rho);
    logic [63:0] q;
    q = (absu(a) * absu(b)) / rho;
    if (q > 64'h2_0000_0000) q = 64'h2_0000_0000;
    return ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint cell_pressure(input longint e, input longint m[3],
                                           input logic [63:0] rho);
    logic [63:0] msq, kin, mag, g, r;
    longint      diff;
    msq = 0;
    for (int j = 0; j < 3; j++) msq += absu(m[j]) * absu(m[j]);
    kin = msq / (2 * rho);
    diff = e - longint'(kin);
    g = 64'(gm1);
    if (g == 0) return 0;
    mag = absu(diff);
    if (mag > ((64'd1 << 47) - 1) / g) r = 64'd1 << 31;
    else r = (mag * g) >> 16;
    if (diff < 0) return longint'($signed(clamp32(-longint'(r))));
    return longint'($signed(clamp32(longint'(r))));
  endfunction

  task automatic predict_flux_rows(input logic [31:0] d, e32, mx, my, mz);
    longint      rho_s, e, p, v;
    longint      m[3];
    logic [63:0] rho;
    logic        bad;
    flux_row_t   fr;
    longint      f[3];
    rho_s = longint'($signed(d));
    e = longint'($signed(e32));
    m[0] = longint'($signed(mx));
    m[1] = DIMS > 1 ? longint'($signed(my)) : 0;
    m[2] = DIMS > 2 ? longint'($signed(mz)) : 0;
    bad = rho_s <= 0;
    rho = bad ? 64'd1 : 64'(rho_s);
    p = bad ? 0 : cell_pressure(e, m, rho);
    if (bad) n_bad_cells++;
    for (int r = 0; r < DIMS + 2; r++) begin
      for (int j = 0; j < 3; j++) begin
        v = 0;
        if (!bad && j < DIMS) begin
          if (r == 0) v = m[j];
          else if (r == 1) v = scaled_quot(m[j], e + p, rho);
          else begin
            v = scaled_quot(m[r-2], m[j], rho);
            if (r - 2 == j) v += p;
          end
        end
        f[j] = v;
      end
      fr.row = 3'(r);
      fr.fx = clamp32(f[0]);
      fr.fy = clamp32(f[1]);
      fr.fz = clamp32(f[2]);
      fr.p = clamp32(p);
      fr.last = (r == DIMS + 1);
      fr.bad = bad;
      flux_rows_due.push_back(fr);
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, exp_v);
    n_errors++;
    if (n_errors <= 30)
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, exp_v, $realtime);
  endtask

  always @(posedge clk) begin
    flux_row_t fr;
    if (rst_n && out_strobe) begin
      n_rows++;
      if (flux_rows_due.size() == 0) report("unexpected word", '0, '0);
      else begin
        fr = flux_rows_due.pop_front();
        if (out_row_index !== fr.row) report("row_index", 32'(out_row_index), 32'(fr.row));
        if (out_flux_x !== fr.fx) report("flux_x", out_flux_x, fr.fx);
        if (out_flux_y !== fr.fy) report("flux_y", out_flux_y, fr.fy);
        if (out_flux_z !== fr.fz) report("flux_z", out_flux_z, fr.fz);
        if (out_cell_pressure !== fr.p) report("cell_pressure", out_cell_pressure, fr.p);
        if (out_last_row !== fr.last) report("last_row", 32'(out_last_row), 32'(fr.last));
        if (out_bad_density !== fr.bad)
          report("bad_density", 32'(out_bad_density), 32'(fr.bad));
      end
    end
  end

  task automatic send_cell(input logic [31:0] d, e, mx, my, mz);
    int gap;
    gap = $urandom_range(0, MAX_GAP);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    in_density = d;
    in_energy = e;
    in_momentum_x = mx;
    in_momentum_y = my;
    in_momentum_z = mz;
    do @(posedge clk); while (busy);
    predict_flux_rows(d, e, mx, my, mz);
    n_cells++;
    @(negedge clk);
  endtask

  task automatic drain;
    start = 1'b0;
    wait (flux_rows_due.size() == 0);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic write_gm1(input logic [17:0] val);
    drain();
    cfg_we = 1'b1;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    gm1 = val;
  endtask

  function automatic logic [31:0] signed_range(input int bits);
    return 32'($signed(32'($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1))));
  endfunction

  task automatic send_random_cell;
    int          kind;
    logic [31:0] d;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      d = 32'($urandom_range(1 << 10, 1 << 22));
      send_cell(d, 32'($urandom_range(0, 1 << 28)), signed_range(22), signed_range(22),
                signed_range(22));
    end else if (kind < 8) begin
      send_cell($urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (kind == 8) begin
      d = 32'($urandom_range(1, 255));
      send_cell(d, $urandom, signed_range(28), signed_range(28), signed_range(28));
    end else begin
      d = ($urandom_range(0, 1) == 1) ? 32'h0 : (32'h8000_0000 | $urandom);
      send_cell(d, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic test_directed_cells;
    send_cell(32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 32'hFFFF_8000, 32'h0);
    send_cell(32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
    send_cell(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1);
    send_cell(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0);
    send_cell(32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_cell(32'h0000_0001, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0);
    send_cell(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
    send_cell(32'h0001_0000, 32'h0, 32'h0004_0000, 32'h0, 32'h0);
    send_cell(32'h0001_0000, 32'h0010_0000, 32'hFFFC_0000, 32'h0003_0000, 32'hFFFF_0000);
    send_cell(32'h0000_0100, 32'h0100_0000, 32'h00FF_0000, 32'hFF00_0000, 32'h0080_0000);
    send_cell(32'h0002_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF);
  endtask

  task automatic test_gm1_extremes;
    logic [17:0] vals[4] = '{18'd0, 18'd131072, 18'h3FFFF, 18'd1};
    foreach (vals[k]) begin
      write_gm1(vals[k]);
      test_directed_cells();
      repeat (8) send_random_cell();
    end
  endtask

  task automatic test_random_cells;
    for (int k = 0; k < 300; k++) begin
      if (k % 75 == 0) write_gm1(18'($urandom_range(0, 131072)));
      send_random_cell();
    end
    for (int k = 0; k < 40; k++) begin
      send_random_cell();
      start = 1'b1;
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    test_directed_cells();
    test_gm1_extremes();
    write_gm1(efc_pkg::GM1_RESET);
    test_random_cells();
    drain();
    $display("Covered %0d cells (%0d bad density), %0d flux words checked.",
             n_cells, n_bad_cells, n_rows);
    if (n_errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #4ms;
    $display("Timeout");
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> sim.f
hdl/efc_pkg.sv
hdl/efc_delay.sv
hdl/efc_div.sv
hdl/euler_flux_from_conserved.sv
dv/tb.sv
